[design/espl_pkg.sv]
`default_nettype none

package espl_pkg;

    localparam int DIFF_W   = 32;
    localparam int CNT_W    = 5;
    localparam int RPM_W    = 24;
    localparam int THR_W    = 12;
    localparam int ALPHA_W  = 9;
    localparam int GAIN_W   = 8;
    localparam int DB_W     = 16;
    localparam int PERIOD_W = 24;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // 60e6 us per minute times 256 for the Q8 result
    localparam int                  SCALE_W = 34;
    localparam logic [SCALE_W-1:0]  SCALE   = 34'd15360000000;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE = 9'd256;

    localparam logic [DB_W-1:0]     DEBOUNCE_RST = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd100000;
    localparam logic [ALPHA_W-1:0]  ALPHA_RST    = 9'd77;
    localparam logic [GAIN_W-1:0]   GAIN_RST     = 8'd51;
    localparam logic [DB_W-1:0]     DEADBAND_RST = 16'd768;
    localparam logic [RPM_W-1:0]    TARGET_RST   = 24'd21274;
    localparam logic [THR_W-1:0]    MIN_THR_RST  = 12'd1250;
    localparam logic [THR_W-1:0]    MAX_THR_RST  = 12'd2000;
    localparam logic [THR_W-1:0]    THR_RST      = 12'd1300;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_PERIOD   = 3'd1,
        REG_ALPHA    = 3'd2,
        REG_GAIN     = 3'd3,
        REG_DEADBAND = 3'd4,
        REG_TARGET   = 3'd5,
        REG_MIN_THR  = 3'd6,
        REG_MAX_THR  = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        R_IDLE,
        R_MUL,
        R_CHK,
        R_DIV,
        R_DONE
    } t_rate_state;

    typedef enum logic [2:0] {
        C_IDLE,
        C_RATE,
        C_EMA,
        C_MIX,
        C_ERR,
        C_PROD,
        C_OUT
    } t_ctl_state;

endpackage

`default_nettype wire

[design/encoder_speed_p_loop_unit.sv]
// Encoder speed measurement with an incremental proportional throttle loop.
// Input stream: s_axis_tuser is the item kind (encoder edge or time tick),
// s_axis_tdata the microsecond timestamp. An edge outside the debounce window
// bumps the pulse counter; an edge, or a tick before the control period has
// passed, produces no output.
// A due tick yields one transfer on the output stream: throttle, smoothed
// RPM (Q8) and pulse count in m_axis_tdata, the deadband flag in m_axis_tuser.
// A due tick runs through the rate unit (a bit-serial multiply, a check
// step, a bit-serial divide and a done step), then through smoothing
// products, average, error, gain product and clamp/load. A zero or
// saturated sample skips the divide. s_axis_tready is low meanwhile, so
// the next item is taken only after the result has been loaded.
// The result sits in an output register; while the receiver stalls the
// block keeps taking items, and a following due tick waits at the end of its
// computation until the register is free.
// Reset restores the default register values, clears counters, times and
// the smoothed speed, and sets the throttle to 1300 us. Configuration is written
// over the APB port by the user only while idle; the block does not enforce it.
`default_nettype none

module encoder_speed_p_loop_unit #(
    parameter int PULSES_PER_TURN = 100,
    parameter int TIME_BITS       = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // [31:0] time_us
    input  wire logic [0:0]                    s_axis_tuser,  // [0] op

    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [11:0] throttle, [35:12] rpm_q8, [67:36] pulses_seen, [71:68] zero
    output logic [71:0]                        m_axis_tdata,
    output logic [0:0]                         m_axis_tuser,  // [0] held

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [espl_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [espl_pkg::DATA_W-1:0]   pwdata,
    output logic [espl_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int TW = (TIME_BITS > 32) ? 32 : TIME_BITS;
    localparam int EW = (TW > espl_pkg::PERIOD_W) ? TW : espl_pkg::PERIOD_W;

    espl_pkg::t_ctl_state r_state, n_state;

    logic [espl_pkg::DB_W-1:0]     r_debounce;
    logic [espl_pkg::PERIOD_W-1:0] r_period;
    logic [espl_pkg::ALPHA_W-1:0]  r_alpha;
    logic [espl_pkg::GAIN_W-1:0]   r_gain;
    logic [espl_pkg::DB_W-1:0]     r_deadband;
    logic [espl_pkg::RPM_W-1:0]    r_target;
    logic [espl_pkg::THR_W-1:0]    r_min_thr;
    logic [espl_pkg::THR_W-1:0]    r_max_thr;

    logic [espl_pkg::DIFF_W-1:0]   r_edge_count;
    logic [TW-1:0]                 r_last_edge;
    logic [TW-1:0]                 r_last_upd;
    logic [espl_pkg::DIFF_W-1:0]   r_count_at_upd;
    logic [espl_pkg::RPM_W-1:0]    r_smoothed;
    logic [espl_pkg::THR_W-1:0]    r_last_thr;

    logic [32:0]                   r_p1;
    logic [32:0]                   r_p2;
    logic signed [24:0]            r_err;
    logic                          r_held;
    logic signed [33:0]            r_prod;

    logic                          r_out_valid;
    logic [espl_pkg::THR_W-1:0]    r_out_thr;
    logic [espl_pkg::RPM_W-1:0]    r_out_rpm;
    logic [espl_pkg::DIFF_W-1:0]   r_out_pulses;
    logic                          r_out_held;

    logic                          w_acc;
    logic                          w_cfg_wr;
    espl_pkg::t_reg_idx            w_reg;
    logic [TW-1:0]                 w_now;
    logic [TW-1:0]                 w_edge_el;
    logic                          w_edge_ok;
    logic [TW-1:0]                 w_dt;
    logic                          w_due;
    logic                          w_start;
    logic                          w_load;
    logic                          w_out_free;
    logic                          w_rate_done;
    logic [espl_pkg::RPM_W-1:0]    w_rate_rpm;
    logic [espl_pkg::DIFF_W-1:0]   w_diff;
    logic [espl_pkg::ALPHA_W-1:0]  w_alpha;
    logic [espl_pkg::ALPHA_W-1:0]  w_beta;
    logic [33:0]                   w_mix;
    logic                          w_held;
    logic signed [17:0]            w_step;
    logic signed [18:0]            w_next;
    logic signed [18:0]            w_hi_cl;
    logic [espl_pkg::THR_W-1:0]    w_clamp;
    logic [espl_pkg::THR_W-1:0]    w_thr;

    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_reg      = espl_pkg::t_reg_idx'(paddr[espl_pkg::ADDR_W-1:2]);
    assign w_now      = s_axis_tdata[TW-1:0];
    assign w_edge_el  = w_now - r_last_edge;
    assign w_edge_ok  = (w_edge_el > TW'(r_debounce));
    assign w_dt       = w_now - r_last_upd;
    assign w_due      = (EW'(w_dt) >= EW'(r_period));
    assign w_diff     = r_edge_count - r_count_at_upd;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_alpha = r_alpha[espl_pkg::ALPHA_W-1] ? espl_pkg::ALPHA_ONE : r_alpha;
    assign w_beta  = espl_pkg::ALPHA_ONE - w_alpha;
    assign w_mix   = 34'(r_p1) + 34'(r_p2) + 34'd128;

    // |target - smoothed| < deadband, without forming the magnitude
    assign w_held = (26'(r_target) < 26'(r_smoothed) + 26'(r_deadband)) &&
                    (26'(r_smoothed) < 26'(r_target) + 26'(r_deadband));

    assign w_step  = r_prod[33:16];
    assign w_next  = $signed({7'b0, r_last_thr}) + $signed({w_step[17], w_step});
    assign w_hi_cl = (w_next > $signed({7'b0, r_max_thr})) ?
                     $signed({7'b0, r_max_thr}) : w_next;
    assign w_clamp = (w_hi_cl < $signed({7'b0, r_min_thr})) ?
                     r_min_thr : w_hi_cl[espl_pkg::THR_W-1:0];
    assign w_thr   = r_held ? r_last_thr : w_clamp;

    espl_rate #(
        .PULSES_PER_TURN (PULSES_PER_TURN),
        .TIME_BITS       (TIME_BITS)
    ) u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_diff  (w_diff),
        .i_dt    (w_dt),
        .o_done  (w_rate_done),
        .o_rpm   (w_rate_rpm)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            espl_pkg::C_IDLE: begin
                if (w_acc && (s_axis_tuser[0] == espl_pkg::OP_TICK) && w_due) begin
                    n_state = espl_pkg::C_RATE;
                end
            end
            espl_pkg::C_RATE: begin
                if (w_rate_done) begin
                    n_state = espl_pkg::C_EMA;
                end
            end
            espl_pkg::C_EMA:  n_state = espl_pkg::C_MIX;
            espl_pkg::C_MIX:  n_state = espl_pkg::C_ERR;
            espl_pkg::C_ERR:  n_state = espl_pkg::C_PROD;
            espl_pkg::C_PROD: n_state = espl_pkg::C_OUT;
            espl_pkg::C_OUT: begin
                if (w_out_free) begin
                    n_state = espl_pkg::C_IDLE;
                end
            end
            default: begin
                n_state = espl_pkg::C_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == espl_pkg::C_IDLE);
        w_start       = (r_state == espl_pkg::C_IDLE) && w_acc &&
                        (s_axis_tuser[0] == espl_pkg::OP_TICK) && w_due;
        w_load        = (r_state == espl_pkg::C_OUT) && w_out_free;
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg)
            espl_pkg::REG_DEBOUNCE: prdata = espl_pkg::DATA_W'(r_debounce);
            espl_pkg::REG_PERIOD:   prdata = espl_pkg::DATA_W'(r_period);
            espl_pkg::REG_ALPHA:    prdata = espl_pkg::DATA_W'(r_alpha);
            espl_pkg::REG_GAIN:     prdata = espl_pkg::DATA_W'(r_gain);
            espl_pkg::REG_DEADBAND: prdata = espl_pkg::DATA_W'(r_deadband);
            espl_pkg::REG_TARGET:   prdata = espl_pkg::DATA_W'(r_target);
            espl_pkg::REG_MIN_THR:  prdata = espl_pkg::DATA_W'(r_min_thr);
            espl_pkg::REG_MAX_THR:  prdata = espl_pkg::DATA_W'(r_max_thr);
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= espl_pkg::DEBOUNCE_RST;
            r_period   <= espl_pkg::PERIOD_RST;
            r_alpha    <= espl_pkg::ALPHA_RST;
            r_gain     <= espl_pkg::GAIN_RST;
            r_deadband <= espl_pkg::DEADBAND_RST;
            r_target   <= espl_pkg::TARGET_RST;
            r_min_thr  <= espl_pkg::MIN_THR_RST;
            r_max_thr  <= espl_pkg::MAX_THR_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                espl_pkg::REG_DEBOUNCE: r_debounce <= pwdata[espl_pkg::DB_W-1:0];
                espl_pkg::REG_PERIOD:   r_period   <= pwdata[espl_pkg::PERIOD_W-1:0];
                espl_pkg::REG_ALPHA:    r_alpha    <= pwdata[espl_pkg::ALPHA_W-1:0];
                espl_pkg::REG_GAIN:     r_gain     <= pwdata[espl_pkg::GAIN_W-1:0];
                espl_pkg::REG_DEADBAND: r_deadband <= pwdata[espl_pkg::DB_W-1:0];
                espl_pkg::REG_TARGET:   r_target   <= pwdata[espl_pkg::RPM_W-1:0];
                espl_pkg::REG_MIN_THR:  r_min_thr  <= pwdata[espl_pkg::THR_W-1:0];
                espl_pkg::REG_MAX_THR:  r_max_thr  <= pwdata[espl_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= espl_pkg::C_IDLE;
            r_edge_count   <= '0;
            r_last_edge    <= '0;
            r_last_upd     <= '0;
            r_count_at_upd <= '0;
            r_smoothed     <= '0;
            r_last_thr     <= espl_pkg::THR_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == espl_pkg::C_IDLE && w_acc &&
                s_axis_tuser[0] == espl_pkg::OP_EDGE && w_edge_ok) begin
                r_edge_count <= r_edge_count + 1'b1;
                r_last_edge  <= w_now;
            end
            if (w_start) begin
                r_count_at_upd <= r_edge_count;
                r_last_upd     <= w_now;
            end
            if (r_state == espl_pkg::C_MIX) begin
                r_smoothed <= w_mix[espl_pkg::RPM_W+7:8];
            end
            if (w_load) begin
                r_last_thr  <= w_thr;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == espl_pkg::C_EMA) begin
            r_p1 <= 33'(w_alpha) * 33'(w_rate_rpm);
            r_p2 <= 33'(w_beta) * 33'(r_smoothed);
        end
        if (r_state == espl_pkg::C_ERR) begin
            r_err  <= $signed({1'b0, r_target}) - $signed({1'b0, r_smoothed});
            r_held <= w_held;
        end
        if (r_state == espl_pkg::C_PROD) begin
            r_prod <= $signed({1'b0, r_gain}) * r_err;
        end
        if (w_load) begin
            r_out_thr    <= w_thr;
            r_out_rpm    <= r_smoothed;
            r_out_pulses <= r_edge_count;
            r_out_held   <= r_held;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_pulses, r_out_rpm, r_out_thr};
    assign m_axis_tuser  = r_out_held;

endmodule

`default_nettype wire

[design/espl_rate.sv]
`default_nettype none

module espl_rate #(
    parameter int PULSES_PER_TURN = 100,
    parameter int TIME_BITS       = 32,
    localparam int TW             = (TIME_BITS > 32) ? 32 : TIME_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [espl_pkg::DIFF_W-1:0]     i_diff,
    input  wire logic [TW-1:0]                   i_dt,
    output logic                                 o_done,
    output logic [espl_pkg::RPM_W-1:0]           o_rpm
);

    localparam int PW = $clog2(PULSES_PER_TURN + 1);
    localparam int DW = PW + TW;
    localparam int NW = espl_pkg::DIFF_W + espl_pkg::SCALE_W;
    localparam int QW = espl_pkg::RPM_W;
    localparam int HW = NW - QW;
    localparam int CW = ((HW > DW) ? HW : DW) + 1;

    espl_pkg::t_rate_state r_state, n_state;

    logic [espl_pkg::CNT_W-1:0]  r_cnt;
    logic [NW-1:0]               r_n;
    logic [NW-1:0]               r_nk;
    logic [espl_pkg::DIFF_W-1:0] r_mpl;
    logic [DW-1:0]               r_d;
    logic [DW-1:0]               r_dk;
    logic [TW-1:0]               r_dt;
    logic [DW-1:0]               r_rem;
    logic [QW-1:0]               r_lo;
    logic [QW-1:0]               r_q;

    logic                        w_mul_end;
    logic                        w_div_end;
    logic                        w_zero;
    logic                        w_ovf;
    logic [DW:0]                 w_shift;
    logic [DW:0]                 w_sub;
    logic                        w_ge;

    assign w_mul_end = (r_cnt == espl_pkg::CNT_W'(espl_pkg::DIFF_W - 1));
    assign w_div_end = (r_cnt == espl_pkg::CNT_W'(QW - 1));
    assign w_zero    = (r_n == '0);
    assign w_ovf     = (CW'(r_n[NW-1:QW]) >= CW'(r_d));
    assign w_shift   = {r_rem, r_lo[QW-1]};
    assign w_sub     = w_shift - {1'b0, r_d};
    assign w_ge      = (w_shift >= {1'b0, r_d});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            espl_pkg::R_IDLE: begin
                if (i_start) begin
                    n_state = espl_pkg::R_MUL;
                end
            end
            espl_pkg::R_MUL: begin
                if (w_mul_end) begin
                    n_state = espl_pkg::R_CHK;
                end
            end
            espl_pkg::R_CHK: begin
                if (w_zero || w_ovf) begin
                    n_state = espl_pkg::R_DONE;
                end else begin
                    n_state = espl_pkg::R_DIV;
                end
            end
            espl_pkg::R_DIV: begin
                if (w_div_end) begin
                    n_state = espl_pkg::R_DONE;
                end
            end
            espl_pkg::R_DONE: begin
                n_state = espl_pkg::R_IDLE;
            end
            default: begin
                n_state = espl_pkg::R_IDLE;
            end
        endcase
    end

    always_comb begin
        o_done = (r_state == espl_pkg::R_DONE);
        o_rpm  = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= espl_pkg::R_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == espl_pkg::R_MUL) || (r_state == espl_pkg::R_DIV)) begin
                if ((r_state == espl_pkg::R_MUL && w_mul_end) ||
                    (r_state == espl_pkg::R_DIV && w_div_end)) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // shift-add products: N = diff * SCALE, D = PULSES_PER_TURN * dt
    // then restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            espl_pkg::R_IDLE: begin
                if (i_start) begin
                    r_n   <= '0;
                    r_nk  <= NW'(espl_pkg::SCALE);
                    r_mpl <= i_diff;
                    r_d   <= '0;
                    r_dk  <= DW'(PULSES_PER_TURN);
                    r_dt  <= i_dt;
                end
            end
            espl_pkg::R_MUL: begin
                if (r_mpl[0]) begin
                    r_n <= r_n + r_nk;
                end
                if (r_dt[0]) begin
                    r_d <= r_d + r_dk;
                end
                r_nk  <= r_nk << 1;
                r_mpl <= r_mpl >> 1;
                r_dk  <= r_dk << 1;
                r_dt  <= r_dt >> 1;
            end
            espl_pkg::R_CHK: begin
                if (w_zero) begin
                    r_q <= '0;
                end else if (w_ovf) begin
                    r_q <= '1;
                end else begin
                    r_rem <= DW'(r_n[NW-1:QW]);
                    r_lo  <= r_n[QW-1:0];
                end
            end
            espl_pkg::R_DIV: begin
                r_rem <= w_ge ? w_sub[DW-1:0] : w_shift[DW-1:0];
                r_lo  <= r_lo << 1;
                r_q   <= {r_q[QW-2:0], w_ge};
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
